[rtl/mexp_pkg.sv]
package mexp_pkg;

    localparam int FIELD_BITS = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SCAN,
        S_SQUARE,
        S_MULT,
        S_DONE
    } t_state;

endpackage

[rtl/mexp_modmul.sv]
module mexp_modmul #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy;
    logic          n_busy;
    logic          r_done;
    logic          n_done;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  n_acc;
    logic [W-1:0]  r_a;
    logic [W-1:0]  n_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  n_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  n_m;
    logic [W-1:0]  dbl;

    // Sum of two residues below the modulus, folded back with one compare.
    function automatic logic [W-1:0] f_add_mod(
        input logic [W-1:0] x,
        input logic [W-1:0] y,
        input logic [W-1:0] m
    );
        logic [W-1:0] gap;
        begin
            gap = m - y;
            f_add_mod = (x >= gap) ? (x - gap) : (x + y);
        end
    endfunction

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        dbl    = f_add_mod(r_acc, r_acc, r_m);
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W - 1);
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            n_acc = r_b[W-1] ? f_add_mod(dbl, r_a, r_m) : dbl;
            n_b   = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[rtl/modular_exponentiation_64_unit.sv]
// A zero modulus goes straight from the accepted transfer to the result strobe.
// Each modular product runs through the shared bit-serial multiplier.
// One item at a time: busy stays high through the result strobe, then drops while the sequencer is idle.
// The result is driven for one cycle with o_valid; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle.
module modular_exponentiation_64_unit
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_BITS-1:0] i_base_value,
    input  logic [FIELD_BITS-1:0] i_exponent_value,
    input  logic [FIELD_BITS-1:0] i_modulus_value,
    output logic                  o_valid,
    output logic [FIELD_BITS-1:0] o_power_result,
    output logic                  o_modulus_error
);

    localparam int W  = OPERAND_BITS;
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    t_state        r_state;
    t_state        n_state;
    logic [W-1:0]  r_base;
    logic [W-1:0]  n_base;
    logic [W-1:0]  r_expo;
    logic [W-1:0]  n_expo;
    logic [W-1:0]  r_mod;
    logic [W-1:0]  n_mod;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  n_acc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_started;
    logic          n_started;
    logic          r_err;
    logic          n_err;

    logic [W-1:0]  in_base;
    logic [W-1:0]  in_mod;
    logic          cur_bit;
    logic          last_bit;
    logic          mul_start;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [W-1:0]  mul_result;

    assign in_base  = i_base_value[W-1:0];
    assign in_mod   = i_modulus_value[W-1:0];
    assign cur_bit  = r_expo[W-1];
    assign last_bit = (r_cnt == '0);

    mexp_modmul #(
        .W(W)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_m      (r_state == S_IDLE ? in_mod : r_mod),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (in_mod == '0) ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_started) begin
                    n_state = S_SQUARE;
                end else if (last_bit) begin
                    n_state = S_DONE;
                end
            end
            S_SQUARE: begin
                if (mul_done) begin
                    if (cur_bit) begin
                        n_state = S_MULT;
                    end else begin
                        n_state = last_bit ? S_DONE : S_SCAN;
                    end
                end
            end
            S_MULT: begin
                if (mul_done) begin
                    n_state = last_bit ? S_DONE : S_SCAN;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_acc;
        mul_b     = r_base;
        busy      = (r_state != S_IDLE);
        o_valid   = (r_state == S_DONE);
        case (r_state)
            S_IDLE: begin
                mul_start = start && (in_mod != '0);
                mul_a     = W'(1);
                mul_b     = in_base;
            end
            S_SCAN: begin
                mul_start = r_started;
                mul_a     = r_acc;
                mul_b     = r_acc;
            end
            S_SQUARE: begin
                mul_start = mul_done && cur_bit;
                mul_a     = mul_result;
                mul_b     = r_base;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_base    = r_base;
        n_expo    = r_expo;
        n_mod     = r_mod;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_started = r_started;
        n_err     = r_err;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_base    = in_base;
                    n_expo    = i_exponent_value[W-1:0];
                    n_mod     = in_mod;
                    n_err     = (in_mod == '0);
                    n_acc     = (in_mod == '0) ? '0 : W'(1);
                    n_cnt     = CW'(W - 1);
                    n_started = 1'b0;
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    n_base = mul_result;
                end
            end
            S_SCAN: begin
                if (!r_started) begin
                    if (cur_bit) begin
                        n_acc     = r_base;
                        n_started = 1'b1;
                    end
                    n_expo = {r_expo[W-2:0], 1'b0};
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            S_SQUARE: begin
                if (mul_done) begin
                    n_acc = mul_result;
                    if (!cur_bit) begin
                        n_expo = {r_expo[W-2:0], 1'b0};
                        n_cnt  = r_cnt - 1'b1;
                    end
                end
            end
            S_MULT: begin
                if (mul_done) begin
                    n_acc  = mul_result;
                    n_expo = {r_expo[W-2:0], 1'b0};
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
        r_base <= n_base;
        r_expo <= n_expo;
        r_mod  <= n_mod;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_err  <= n_err;
    end

    assign o_power_result  = FIELD_BITS'(r_acc);
    assign o_modulus_error = r_err;

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_modulus_error) |-> (o_power_result == '0))
        else $error("modulus error reported with a nonzero result");

    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transfer");

    a_mul_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_REDUCE || r_state == S_SQUARE || r_state == S_MULT))
        else $error("multiplier finished while the sequencer was not waiting");

endmodule

[bench/testbench.sv]
module testbench;
    import mexp_pkg::*;

    localparam int OPERAND_BITS = 64;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 16;

    typedef logic [FIELD_BITS-1:0] word_t;

    typedef struct packed {
        word_t power;
        logic  mod_err;
    } power_expect_t;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    word_t i_base_value;
    word_t i_exponent_value;
    word_t i_modulus_value;
    logic  o_valid;
    word_t o_power_result;
    logic  o_modulus_error;

    power_expect_t pending_powers[$];
    int error_count = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;

    modular_exponentiation_64_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_base_value(i_base_value),
        .i_exponent_value(i_exponent_value),
        .i_modulus_value(i_modulus_value),
        .o_valid(o_valid),
        .o_power_result(o_power_result),
        .o_modulus_error(o_modulus_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic power_expect_t predict_power(input word_t base_in, input word_t expo_in,
                                                    input word_t mod_in);
        word_t         keep;
        word_t         base_red;
        word_t         expo;
        word_t         modulus;
        word_t         acc;
        logic [127:0]  prod;
        logic          seen;
        power_expect_t r;
        keep = (OPERAND_BITS >= 64) ? {FIELD_BITS{1'b1}} : ((64'd1 << OPERAND_BITS) - 64'd1);
        expo = expo_in & keep;
        modulus = mod_in & keep;
        if (modulus == 0) begin
            r.power = '0;
            r.mod_err = 1'b1;
            return r;
        end
        base_red = (base_in & keep) % modulus;
        acc = 64'd1;
        seen = 1'b0;
        for (int i = OPERAND_BITS - 1; i >= 0; i--) begin
            if (seen) begin
                prod = {64'd0, acc} * {64'd0, acc};
                acc = word_t'(prod % {64'd0, modulus});
                if (expo[i]) begin
                    prod = {64'd0, acc} * {64'd0, base_red};
                    acc = word_t'(prod % {64'd0, modulus});
                end
            end else if (expo[i]) begin
                acc = base_red;
                seen = 1'b1;
            end
        end
        r.power = acc & keep;
        r.mod_err = 1'b0;
        return r;
    endfunction

    function automatic word_t rand_word(input int bits);
        word_t w;
        w = {$urandom, $urandom};
        return w & ((64'd1 << bits) - 64'd1);
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_item(input word_t base_in, input word_t expo_in, input word_t mod_in);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                while (busy) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_base_value <= base_in;
        i_exponent_value <= expo_in;
        i_modulus_value <= mod_in;
        do @(posedge i_clk); while (busy);
        pending_powers.push_back(predict_power(base_in, expo_in, mod_in));
    endtask

    always @(posedge i_clk) begin
        power_expect_t want;
        if (i_rst_n && o_valid) begin
            if (pending_powers.size() == 0) begin
                report_mismatch("result with nothing pending", o_power_result, '0);
            end else begin
                want = pending_powers.pop_front();
                if (o_power_result !== want.power) begin
                    report_mismatch("power_result", o_power_result, want.power);
                end
                if (o_modulus_error !== want.mod_err) begin
                    report_mismatch("modulus_error", word_t'(o_modulus_error),
                                    word_t'(want.mod_err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic test_zero_modulus();
        send_item('1, '1, '0);
        send_item('0, '0, '0);
        send_item(64'h0123_4567_89ab_cdef, 64'd0, '0);
    endtask

    task automatic test_zero_exponent();
        send_item(64'd5, 64'd0, 64'd1);
        send_item('1, 64'd0, '1);
        send_item('0, 64'd0, 64'd7);
    endtask

    task automatic test_operand_extremes();
        send_item(64'd12345, 64'd77, 64'd1);
        send_item(64'd0, 64'd5, 64'd7);
        send_item('1, 64'd1, '1);
        send_item('1, 64'd1, 64'hffff_ffff_ffff_fffe);
        send_item('1, '1, '1);
        send_item(64'd2, '1, 64'hffff_ffff_ffff_ffc5);
        send_item(64'hdead_beef_cafe_f00d, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffc5);
        send_item(64'd3, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000);
        send_item('1, 64'haaaa_aaaa_aaaa_aaaa, 64'h0000_0001_0000_0001);
        send_item(64'd1000, 64'd3, 64'd10);
        send_item(64'd4, 64'd13, 64'd497);
        send_item(64'd2, 64'd64, 64'd3);
    endtask

    task automatic random_item();
        int    pick;
        word_t base_in;
        word_t expo_in;
        word_t mod_in;
        pick = $urandom_range(0, 9);
        base_in = rand_word($urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : 64);
        expo_in = rand_word($urandom_range(1, 64));
        mod_in = rand_word($urandom_range(0, 1) == 0 ? $urandom_range(1, 64) : 64);
        if (pick == 0) begin
            mod_in = '0;
            expo_in = rand_word(64);
        end else if (pick == 1) begin
            expo_in = '0;
        end else if (pick == 2) begin
            mod_in = rand_word($urandom_range(1, 4));
        end
        send_item(base_in, expo_in, mod_in);
    endtask

    task automatic test_random_with_idle();
        idle_on = 1'b1;
        repeat (80) random_item();
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        repeat (20) random_item();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_base_value <= '0;
        i_exponent_value <= '0;
        i_modulus_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_modulus();
        test_zero_exponent();
        test_operand_extremes();
        test_random_with_idle();
        test_random_back_to_back();
        start <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
